// File: rtl/tpps_pkg.sv
// Shared types and constants for the toggle power pulse sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tpps_pkg;

    // Width of the since-toggle counter and the receive backoff
    localparam int COUNT_BITS = 24;

    localparam int TICK_BITS      = 16;
    localparam int OP_BITS        = 3;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [TICK_BITS-1:0] PULSE_TICKS_RESET   = 16'd10;
    localparam logic [TICK_BITS-1:0] SETTLE_TICKS_RESET  = 16'd10;
    localparam logic [TICK_BITS-1:0] BACKOFF_START_RESET = 16'd1000;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK      = 3'd0,
        OP_SET_REQ   = 3'd1,
        OP_RX_ACT    = 3'd2,
        OP_SET_BLOCK = 3'd3,
        OP_SUSPEND   = 3'd4,
        OP_RESUME    = 3'd5
    } t_op;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PULSE_TICKS   = 2'd0,
        CFG_SETTLE_TICKS  = 2'd1,
        CFG_BACKOFF_START = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               value;
    } t_in_item;

    typedef struct packed {
        logic       pin_level;
        logic       amp_enable;
        logic       rx_monitor;
        logic       believed_on;
        logic [1:0] phase_out;
    } t_out_item;

    typedef struct packed {
        logic [TICK_BITS-1:0] pulse_ticks;
        logic [TICK_BITS-1:0] settle_ticks;
        logic [TICK_BITS-1:0] backoff_start;
    } t_cfg;

endpackage

`default_nettype wire

// File: rtl/toggle_power_pulse_sequencer.sv
// Top level of the toggle power pulse sequencer: input and result registers
// around tpps_core, plus the configuration registers. Depends on tpps_pkg,
// tpps_cfg_regs and tpps_core.
//
// Usage:
//   Event channel: i_in_valid / o_in_stall carry one event request (op, value)
//   per accepted edge. Result channel: o_out_valid / i_out_stall return one
//   result per event: pin level, amplifier enable, receive monitor, believed
//   device state and phase, all as they stand after the event.
//   Config channel: i_cfg_valid / o_cfg_ready write pulse ticks (index 0),
//   settle ticks (1) and backoff start (2); ready is always high. Write only
//   while no event is outstanding.
//   Flow: an accepted event waits in the input register and moves into the
//   result register, where its result is offered, once that register has room.
//   Throughput: one event per cycle while the result channel is not stalled.
//   Stall: a stalled result holds in the result register; the input register
//   still takes one more request, then o_in_stall rises until the result
//   moves on.
//   Reset: synchronous, active low; both registers empty, state and
//   configuration back to their power-on values.
`timescale 1ns / 1ps
`default_nettype none

module toggle_power_pulse_sequencer (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire tpps_pkg::t_in_item                    i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output tpps_pkg::t_out_item                        o_out_data,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [tpps_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [tpps_pkg::TICK_BITS-1:0]        i_cfg_data
);
    import tpps_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_cfg      cfg;
    t_out_item result;
    logic      advance;
    logic      in_take;

    // move the held request into the result register when it has room
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    tpps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tpps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tpps_cfg_regs.sv
// Configuration register file: pulse, settle and backoff start tick counts.
// Depends on tpps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpps_cfg_regs (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [tpps_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [tpps_pkg::TICK_BITS-1:0]        i_cfg_data,
    output tpps_pkg::t_cfg                             o_cfg
);
    import tpps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PULSE_TICKS:   n_cfg.pulse_ticks   = i_cfg_data;
                CFG_SETTLE_TICKS:  n_cfg.settle_ticks  = i_cfg_data;
                CFG_BACKOFF_START: n_cfg.backoff_start = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ticks   <= PULSE_TICKS_RESET;
            r_cfg.settle_ticks  <= SETTLE_TICKS_RESET;
            r_cfg.backoff_start <= BACKOFF_START_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tpps_core.sv
// Sequencer state and next-state logic: one event per enabled cycle.
// Depends on tpps_pkg; result is the state after the event, unregistered.
`timescale 1ns / 1ps
`default_nettype none

module tpps_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire tpps_pkg::t_in_item  i_item,
    input  wire tpps_pkg::t_cfg      i_cfg,
    output tpps_pkg::t_out_item      o_result
);
    import tpps_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PULSE  = 2'd1,
        PH_SETTLE = 2'd2,
        PH_SUSP   = 2'd3
    } t_phase;

    localparam logic [COUNT_BITS-1:0] CNT_MAX           = '1;
    localparam logic [COUNT_BITS-1:0] BACKOFF_NOW_RESET =
        {{(COUNT_BITS-TICK_BITS){1'b0}}, BACKOFF_START_RESET};

    t_phase                r_phase,   n_phase;
    logic [TICK_BITS-1:0]  r_timer,   n_timer;
    logic                  r_dev_on,  n_dev_on;
    logic                  r_want_on, n_want_on;
    logic                  r_check,   n_check;
    logic                  r_asleep,  n_asleep;
    logic                  r_blocked, n_blocked;
    logic                  r_monitor, n_monitor;
    logic                  r_pin,     n_pin;
    logic [COUNT_BITS-1:0] r_since,   n_since;
    logic [COUNT_BITS-1:0] r_backoff, n_backoff;

    logic [TICK_BITS-1:0]  timer_inc;
    logic                  pulse_done;
    logic                  settle_done;
    logic                  dev_mid;

    assign timer_inc   = r_timer + 1'b1;
    assign pulse_done  = (timer_inc >= i_cfg.pulse_ticks)  || (timer_inc == '0);
    assign settle_done = (timer_inc >= i_cfg.settle_ticks) || (timer_inc == '0);
    // A pulse cut short by suspend still counts as a completed toggle
    assign dev_mid     = (r_phase == PH_PULSE) ? !r_dev_on : r_dev_on;

    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_dev_on  = r_dev_on;
        n_want_on = r_want_on;
        n_check   = r_check;
        n_asleep  = r_asleep;
        n_blocked = r_blocked;
        n_monitor = r_monitor;
        n_pin     = r_pin;
        n_since   = r_since;
        n_backoff = r_backoff;

        case (t_op'(i_item.op))
            OP_TICK: begin
                if (r_since != CNT_MAX) begin
                    n_since = r_since + 1'b1;
                end
                if (r_phase == PH_SUSP) begin
                    n_timer = timer_inc;
                    if (pulse_done) begin
                        n_pin    = 1'b1;
                        n_dev_on = 1'b0;
                        n_phase  = PH_IDLE;
                        n_timer  = '0;
                    end
                end else if (!r_asleep) begin
                    case (r_phase)
                        PH_PULSE: begin
                            n_timer = timer_inc;
                            if (pulse_done) begin
                                n_pin    = 1'b1;
                                n_since  = '0;
                                n_dev_on = !r_dev_on;
                                n_phase  = PH_SETTLE;
                                n_timer  = '0;
                            end
                        end
                        PH_SETTLE: begin
                            n_timer = timer_inc;
                            // re-run the idle check so a late request is not lost
                            if (settle_done) begin
                                n_phase = PH_IDLE;
                                n_timer = '0;
                                n_check = 1'b1;
                            end
                        end
                        default: begin
                            if (r_check) begin
                                n_check = 1'b0;
                                if (r_want_on == r_dev_on) begin
                                    if (!r_dev_on) begin
                                        n_monitor = 1'b1;
                                    end
                                end else begin
                                    n_pin   = 1'b0;
                                    n_phase = PH_PULSE;
                                    n_timer = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            OP_SET_REQ: begin
                if (i_item.value && !r_want_on) begin
                    n_monitor = 1'b0;
                    n_want_on = 1'b1;
                    n_check   = 1'b1;
                end else if (!i_item.value && r_want_on) begin
                    n_backoff = {{(COUNT_BITS-TICK_BITS){1'b0}}, i_cfg.backoff_start};
                    n_want_on = 1'b0;
                    n_check   = 1'b1;
                end
            end
            OP_RX_ACT: begin
                // activity while believed off proves the device is on
                if (r_monitor && !r_want_on && !r_dev_on && (r_phase == PH_IDLE) &&
                    (r_since > r_backoff)) begin
                    n_dev_on  = 1'b1;
                    n_backoff = r_backoff[COUNT_BITS-1] ? CNT_MAX
                                                        : {r_backoff[COUNT_BITS-2:0], 1'b0};
                    n_check   = 1'b1;
                end
            end
            OP_SET_BLOCK: begin
                n_blocked = i_item.value;
            end
            OP_SUSPEND: begin
                n_asleep = 1'b1;
                n_check  = 1'b0;
                if (r_phase != PH_SUSP) begin
                    if (r_phase == PH_PULSE) begin
                        n_pin   = 1'b1;
                        n_since = '0;
                    end
                    n_dev_on = dev_mid;
                    n_phase  = PH_IDLE;
                    n_timer  = '0;
                    if (dev_mid) begin
                        n_pin   = 1'b0;
                        n_phase = PH_SUSP;
                    end
                end
            end
            OP_RESUME: begin
                n_asleep = 1'b0;
                n_check  = 1'b1;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (n_asleep) begin
            n_check = 1'b0;
        end
    end

    always_comb begin
        o_result.pin_level   = n_pin;
        o_result.amp_enable  = n_want_on && !n_blocked && !n_asleep;
        o_result.rx_monitor  = n_monitor;
        o_result.believed_on = n_dev_on;
        o_result.phase_out   = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_timer   <= '0;
            r_dev_on  <= 1'b0;
            r_want_on <= 1'b1;
            r_check   <= 1'b0;
            r_asleep  <= 1'b0;
            r_blocked <= 1'b1;
            r_monitor <= 1'b0;
            r_pin     <= 1'b0;
            r_since   <= '0;
            r_backoff <= BACKOFF_NOW_RESET;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_dev_on  <= n_dev_on;
            r_want_on <= n_want_on;
            r_check   <= n_check;
            r_asleep  <= n_asleep;
            r_blocked <= n_blocked;
            r_monitor <= n_monitor;
            r_pin     <= n_pin;
            r_since   <= n_since;
            r_backoff <= n_backoff;
        end
    end

endmodule

`default_nettype wire

// File: test/toggle_power_pulse_sequencer_tb.sv
// Self-checking bench for toggle_power_pulse_sequencer: a queue-fed event driver,
// a result monitor with random stalls and a cycle-free sequencer predictor.
// Depends on tpps_pkg and the toggle_power_pulse_sequencer top level.
`timescale 1ns / 1ps

module toggle_power_pulse_sequencer_tb;

    import tpps_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_PULSE  = 2'd1;
    localparam logic [1:0] PH_SETTLE = 2'd2;
    localparam logic [1:0] PH_SUSP   = 2'd3;

    localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd7;

    localparam bit [COUNT_BITS-1:0] CNT_MAX = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid  = 1'b0;
    t_in_item                  in_data   = '0;
    logic                      out_stall = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [TICK_BITS-1:0]      cfg_data  = '0;

    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      cfg_ready;

    toggle_power_pulse_sequencer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    t_in_item  event_q[$];
    t_out_item status_q[$];

    int mismatches    = 0;
    bit quiet_mode    = 1'b0;
    int hold_off_req  = 0;
    int hold_off_seen = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int free_left     = 0;

    // predictor state and its copy of the timing registers
    bit [TICK_BITS-1:0]  m_pulse_ticks;
    bit [TICK_BITS-1:0]  m_settle_ticks;
    bit [TICK_BITS-1:0]  m_backoff_start;
    bit [1:0]            m_phase;
    bit [TICK_BITS-1:0]  m_timer;
    bit                  m_dev_on;
    bit                  m_want_on;
    bit                  m_check;
    bit                  m_asleep;
    bit                  m_blocked;
    bit                  m_monitor;
    bit                  m_pin;
    bit [COUNT_BITS-1:0] m_since;
    bit [COUNT_BITS-1:0] m_backoff;

    function automatic bit timer_expired(bit [TICK_BITS-1:0] limit);
        m_timer = m_timer + 1'b1;
        return (m_timer >= limit) || (m_timer == '0);
    endfunction

    function automatic void complete_toggle();
        m_pin    = 1'b1;
        m_since  = '0;
        m_dev_on = !m_dev_on;
    endfunction

    function automatic t_out_item advance_sequencer(t_in_item ev);
        t_out_item r;
        case (ev.op)
            OP_TICK: begin
                if (m_since != CNT_MAX)
                    m_since = m_since + 1'b1;
                if (m_phase == PH_SUSP) begin
                    if (timer_expired(m_pulse_ticks)) begin
                        m_pin    = 1'b1;
                        m_dev_on = 1'b0;
                        m_phase  = PH_IDLE;
                        m_timer  = '0;
                    end
                end else if (!m_asleep) begin
                    case (m_phase)
                        PH_PULSE: begin
                            if (timer_expired(m_pulse_ticks)) begin
                                complete_toggle();
                                m_phase = PH_SETTLE;
                                m_timer = '0;
                            end
                        end
                        PH_SETTLE: begin
                            // re-run the idle check so a late request is not lost
                            if (timer_expired(m_settle_ticks)) begin
                                m_phase = PH_IDLE;
                                m_timer = '0;
                                m_check = 1'b1;
                            end
                        end
                        default: begin
                            if (m_check) begin
                                m_check = 1'b0;
                                if (m_want_on == m_dev_on) begin
                                    if (!m_dev_on)
                                        m_monitor = 1'b1;
                                end else begin
                                    m_pin   = 1'b0;
                                    m_phase = PH_PULSE;
                                    m_timer = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            OP_SET_REQ: begin
                if (ev.value && !m_want_on) begin
                    m_monitor = 1'b0;
                    m_want_on = 1'b1;
                    m_check   = 1'b1;
                end else if (!ev.value && m_want_on) begin
                    m_backoff = COUNT_BITS'(m_backoff_start);
                    m_want_on = 1'b0;
                    m_check   = 1'b1;
                end
            end
            OP_RX_ACT: begin
                // activity only proves the device is on once the backoff has run out
                if (m_monitor && !m_want_on && !m_dev_on && m_phase == PH_IDLE &&
                    m_since > m_backoff) begin
                    m_dev_on  = 1'b1;
                    m_backoff = (m_backoff > (CNT_MAX >> 1)) ? CNT_MAX : (m_backoff << 1);
                    m_check   = 1'b1;
                end
            end
            OP_SET_BLOCK: m_blocked = ev.value;
            OP_SUSPEND: begin
                m_asleep = 1'b1;
                m_check  = 1'b0;
                if (m_phase != PH_SUSP) begin
                    if (m_phase == PH_PULSE)
                        complete_toggle();
                    m_phase = PH_IDLE;
                    m_timer = '0;
                    if (m_dev_on) begin
                        m_pin   = 1'b0;
                        m_phase = PH_SUSP;
                    end
                end
            end
            OP_RESUME: begin
                m_asleep = 1'b0;
                m_check  = 1'b1;
            end
            default: ;
        endcase
        if (m_asleep)
            m_check = 1'b0;
        r.pin_level   = m_pin;
        r.amp_enable  = m_want_on && !m_blocked && !m_asleep;
        r.rx_monitor  = m_monitor;
        r.believed_on = m_dev_on;
        r.phase_out   = m_phase;
        return r;
    endfunction

    // mostly zero, some short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [1:0] got, logic [1:0] want_v);
        if (got !== want_v)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want_v));
    endtask

    // event driver: predict on acceptance, then advance to the next request
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                status_q.push_back(advance_sequencer(in_data));
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (event_q.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= event_q.pop_front();
                    gap_left = pick_idle();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk) begin : result_monitor
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (status_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = status_q.pop_front();
                    check_field("pin_level", 2'(out_data.pin_level), 2'(want.pin_level));
                    check_field("amp_enable", 2'(out_data.amp_enable),
                                2'(want.amp_enable));
                    check_field("rx_monitor", 2'(out_data.rx_monitor),
                                2'(want.rx_monitor));
                    check_field("believed_on", 2'(out_data.believed_on),
                                2'(want.believed_on));
                    check_field("phase_out", out_data.phase_out, want.phase_out);
                end
            end
            if (hold_off_seen != hold_off_req) begin
                hold_off_seen = hold_off_req;
                stall_left    = 200;
                free_left     = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (free_left > 0) begin
                free_left--;
                out_stall <= 1'b0;
            end else begin
                free_left  = $urandom_range(0, 24);
                stall_left = pick_idle();
                out_stall <= 1'b0;
            end
        end
    end

    // write all three timing registers back to back; call from a rising edge
    task automatic load_timing(logic [TICK_BITS-1:0] pulse, logic [TICK_BITS-1:0] settle,
                               logic [TICK_BITS-1:0] backoff);
        logic [TICK_BITS-1:0] vals [3];
        vals = '{pulse, settle, backoff};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= t_cfg_index'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            case (t_cfg_index'(i))
                CFG_PULSE_TICKS:   m_pulse_ticks   = vals[i];
                CFG_SETTLE_TICKS:  m_settle_ticks  = vals[i];
                CFG_BACKOFF_START: m_backoff_start = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // hold until every request is in and answered, then let the pipeline empty
    task automatic wait_drained();
        do @(negedge clk); while (event_q.size() != 0 || in_valid || status_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(logic [TICK_BITS-1:0] pulse, logic [TICK_BITS-1:0] settle,
                             logic [TICK_BITS-1:0] backoff, int count, bit no_idle,
                             bit long_hold);
        t_in_item ev;
        int       r;
        bit       asleep_guess;
        load_timing(pulse, settle, backoff);
        quiet_mode <= no_idle;
        if (long_hold)
            hold_off_req <= hold_off_req + 1;
        @(negedge clk);
        asleep_guess = 1'b0;
        repeat (count) begin
            r        = $urandom_range(0, 99);
            ev.value = 1'($urandom);
            // mostly ticks with requests and activity; wake up soon after a suspend
            if (asleep_guess && r < 35)
                ev.op = OP_RESUME;
            else if (r < 55)
                ev.op = OP_TICK;
            else if (r < 67)
                ev.op = OP_SET_REQ;
            else if (r < 79)
                ev.op = OP_RX_ACT;
            else if (r < 86)
                ev.op = OP_SET_BLOCK;
            else if (r < 91)
                ev.op = OP_SUSPEND;
            else if (r < 98)
                ev.op = OP_RESUME;
            else
                ev.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            if (ev.op == OP_SUSPEND)
                asleep_guess = 1'b1;
            else if (ev.op == OP_RESUME)
                asleep_guess = 1'b0;
            event_q.push_back(ev);
        end
        wait_drained();
        quiet_mode <= 1'b0;
    endtask

    initial begin
        m_pulse_ticks   = PULSE_TICKS_RESET;
        m_settle_ticks  = SETTLE_TICKS_RESET;
        m_backoff_start = BACKOFF_START_RESET;
        m_phase         = PH_IDLE;
        m_timer         = '0;
        m_dev_on        = 1'b0;
        m_want_on       = 1'b1;
        m_check         = 1'b0;
        m_asleep        = 1'b0;
        m_blocked       = 1'b1;
        m_monitor       = 1'b0;
        m_pin           = 1'b0;
        m_since         = '0;
        m_backoff       = COUNT_BITS'(BACKOFF_START_RESET);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through suspend, receive proof and late requests
        load_timing(16'd2, 16'd1, 16'd3);
        @(negedge clk);
        event_q.push_back(t_in_item'{OP_TICK, 1'b0});
        event_q.push_back(t_in_item'{OP_SET_BLOCK, 1'b0});
        event_q.push_back(t_in_item'{OP_SET_REQ, 1'b1});
        event_q.push_back(t_in_item'{OP_RESUME, 1'b0});
        event_q.push_back(t_in_item'{OP_TICK, 1'b1});
        event_q.push_back(t_in_item'{OP_SUSPEND, 1'b0});
        event_q.push_back(t_in_item'{OP_SUSPEND, 1'b1});
        event_q.push_back(t_in_item'{OP_TICK, 1'b0});
        event_q.push_back(t_in_item'{OP_TICK, 1'b0});
        event_q.push_back(t_in_item'{OP_SUSPEND, 1'b0});
        event_q.push_back(t_in_item'{OP_RESUME, 1'b1});
        event_q.push_back(t_in_item'{OP_SET_REQ, 1'b0});
        event_q.push_back(t_in_item'{OP_TICK, 1'b0});
        event_q.push_back(t_in_item'{OP_RX_ACT, 1'b0});
        event_q.push_back(t_in_item'{OP_TICK, 1'b0});
        event_q.push_back(t_in_item'{OP_RX_ACT, 1'b1});
        event_q.push_back(t_in_item'{OP_TICK, 1'b0});
        event_q.push_back(t_in_item'{OP_SET_REQ, 1'b1});
        event_q.push_back(t_in_item'{OP_TICK, 1'b0});
        event_q.push_back(t_in_item'{OP_TICK, 1'b0});
        event_q.push_back(t_in_item'{OP_SUSPEND, 1'b0});
        event_q.push_back(t_in_item'{OP_RESUME, 1'b0});
        event_q.push_back(t_in_item'{OP_TICK, 1'b0});
        event_q.push_back(t_in_item'{OP_SPARE_A, 1'b1});
        event_q.push_back(t_in_item'{OP_SPARE_B, 1'b0});
        event_q.push_back(t_in_item'{OP_SET_BLOCK, 1'b1});
        wait_drained();

        run_phase(16'd10, 16'd10, 16'd1000, 150, 1'b0, 1'b0);
        run_phase(16'd1, 16'd1, 16'd1, 350, 1'b0, 1'b0);
        run_phase(16'd3, 16'd2, 16'd20, 350, 1'b1, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 80, 1'b0, 1'b0);
        repeat (4)
            run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                      16'($urandom_range(1, 60)), 250, 1'b0, 1'b0);

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
